@@ rtl/core/deadline_monotonic_ready_queue_core_defines.svh @@
// Assertion macros for the deadline-monotonic ready queue.
// Used by the port checker; expects clk_i and rst_ni in the using scope.
`ifndef DEADLINE_MONOTONIC_READY_QUEUE_CORE_DEFINES_SVH
`define DEADLINE_MONOTONIC_READY_QUEUE_CORE_DEFINES_SVH

// Clocked property, masked while reset is asserted
`define DMRQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same-cycle implication, masked while reset is asserted
`define DMRQ_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/dmrq_pkg.sv @@
// Shared constants and types for the deadline-monotonic ready queue.
// No dependencies; used by the interfaces, the core and the checker.
`timescale 1ns / 1ps

package dmrq_pkg;

  // Queue geometry
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned IdxW       = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  // Field widths
  localparam int unsigned JobW   = 8;
  localparam int unsigned DlW    = 16;
  localparam int unsigned CountW = 5;

  // Request codes
  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_REMOVE = 1'b1;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  // One stored job
  typedef struct packed {
    logic [JobW-1:0] job;
    logic [DlW-1:0]  deadline;
  } entry_t;

endpackage

@@ rtl/core/dmrq_if.sv @@
// Handshake interfaces for the request and response channels.
// Depends on dmrq_pkg for field widths.
`timescale 1ns / 1ps

interface dmrq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [dmrq_pkg::JobW-1:0]  job_id;
  logic [dmrq_pkg::DlW-1:0]   rel_deadline;

  modport source (output valid, output req_type, output job_id, output rel_deadline,
                  input ready);
  modport sink   (input valid, input req_type, input job_id, input rel_deadline,
                  output ready);
endinterface

interface dmrq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        head_valid;
  logic [dmrq_pkg::JobW-1:0]   head_job_id;
  logic [dmrq_pkg::CountW-1:0] job_count;
  logic                        error;

  modport source (output valid, output head_valid, output head_job_id, output job_count,
                  output error, input ready);
  modport sink   (input valid, input head_valid, input head_job_id, input job_count,
                  input error, output ready);
endinterface

@@ rtl/core/deadline_monotonic_ready_queue_core.sv @@
// Deadline-monotonic ready queue: add/remove jobs, report earliest-deadline head.
// Depends on dmrq_pkg and the interfaces in dmrq_if.sv.
`timescale 1ns / 1ps
//
//  channel | dir | word
//  --------+-----+--------------------------------------------------
//  req_i   | in  | req_type, job_id, rel_deadline
//  rsp_o   | out | head_valid, head_job_id, job_count, error
//
//  An item is scanned with one read per slot through the single
//  read port of the entry memory, plus setup and finish.
//  Reset clears the valid bits and the job count; the entry memory needs no clear.
//  A result waits in the output register; the next word is taken meanwhile, and
//  its finish step stalls until the earlier result has been taken.

module deadline_monotonic_ready_queue_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  dmrq_req_if.sink    req_i,
  dmrq_rsp_if.source  rsp_o
);

  typedef enum logic [1:0] {StIdle, StScan, StLast, StFinish} state_e;

  localparam dmrq_pkg::idx_t IdxLast = dmrq_pkg::idx_t'(dmrq_pkg::QueueDepth - 1);

  state_e                          state_q;
  logic [dmrq_pkg::QueueDepth-1:0] valid_q;
  dmrq_pkg::cnt_t                  count_q;

  // entry store and its registered read port
  dmrq_pkg::entry_t mem [dmrq_pkg::QueueDepth];
  dmrq_pkg::entry_t rd_data_q;
  dmrq_pkg::idx_t   rd_idx_q;
  logic             cmp_vld_q;
  dmrq_pkg::idx_t   cmp_idx_q;

  // current item
  logic                      op_rem_q;
  logic [dmrq_pkg::JobW-1:0] job_q;
  logic                      add_ok_q;
  dmrq_pkg::idx_t            add_slot_q;
  logic                      found_q;
  dmrq_pkg::idx_t            found_idx_q;

  // running head
  logic                      best_vld_q;
  logic [dmrq_pkg::DlW-1:0]  best_dl_q;
  logic [dmrq_pkg::JobW-1:0] best_id_q;

  // result register
  logic                        rsp_vld_q;
  logic                        rsp_head_vld_q;
  logic [dmrq_pkg::JobW-1:0]   rsp_head_id_q;
  logic [dmrq_pkg::CountW-1:0] rsp_count_q;
  logic                        rsp_err_q;

  logic           accept;
  logic           free_any;
  dmrq_pkg::idx_t free_idx;
  logic           add_ok;
  logic           hit;
  logic           match;
  logic           better;
  logic           finish;
  dmrq_pkg::cnt_t count_nxt;
  logic [dmrq_pkg::QueueDepth-1:0] valid_nxt;

  assign req_i.ready = (state_q == StIdle);
  assign accept      = req_i.valid && req_i.ready;

  // lowest free slot
  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = dmrq_pkg::QueueDepth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = dmrq_pkg::idx_t'(i);
      end
    end
  end

  assign add_ok = (req_i.req_type == dmrq_pkg::REQ_ADD) && free_any;

  // memory: write the new entry at accept, read one slot per scan cycle
  always_ff @(posedge clk_i) begin
    if (accept && add_ok) begin
      mem[free_idx] <= '{job: req_i.job_id, deadline: req_i.rel_deadline};
    end
    rd_data_q <= mem[rd_idx_q];
  end

  // compare stage: first matching slot is the one removed, the rest feed the head
  assign hit    = cmp_vld_q && valid_q[cmp_idx_q];
  assign match  = hit && op_rem_q && !found_q && (rd_data_q.job == job_q);
  assign better = hit && !match &&
                  (!best_vld_q || (rd_data_q.deadline < best_dl_q) ||
                   ((rd_data_q.deadline == best_dl_q) && (rd_data_q.job < best_id_q)));

  assign finish = (state_q == StFinish) && (!rsp_vld_q || rsp_o.ready);

  // state update at finish
  always_comb begin
    valid_nxt = valid_q;
    count_nxt = count_q;
    if (!op_rem_q && add_ok_q) begin
      valid_nxt[add_slot_q] = 1'b1;
      count_nxt             = count_q + 1'b1;
    end else if (op_rem_q && found_q) begin
      valid_nxt[found_idx_q] = 1'b0;
      count_nxt              = count_q - 1'b1;
    end
  end

  // sequencer, scan pipeline and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= StIdle;
      valid_q        <= '0;
      count_q        <= '0;
      rd_idx_q       <= '0;
      cmp_vld_q      <= 1'b0;
      cmp_idx_q      <= '0;
      op_rem_q       <= 1'b0;
      job_q          <= '0;
      add_ok_q       <= 1'b0;
      add_slot_q     <= '0;
      found_q        <= 1'b0;
      found_idx_q    <= '0;
      best_vld_q     <= 1'b0;
      best_dl_q      <= '0;
      best_id_q      <= '0;
      rsp_vld_q      <= 1'b0;
      rsp_head_vld_q <= 1'b0;
      rsp_head_id_q  <= '0;
      rsp_count_q    <= '0;
      rsp_err_q      <= 1'b0;
    end else begin
      cmp_vld_q <= (state_q == StScan);
      cmp_idx_q <= rd_idx_q;

      if (match) begin
        found_q     <= 1'b1;
        found_idx_q <= cmp_idx_q;
      end
      if (better) begin
        best_vld_q <= 1'b1;
        best_dl_q  <= rd_data_q.deadline;
        best_id_q  <= rd_data_q.job;
      end

      // result taken; a finish in the same cycle refills it below
      if (rsp_vld_q && rsp_o.ready && !finish) begin
        rsp_vld_q <= 1'b0;
      end

      case (state_q)
        StIdle: begin
          if (accept) begin
            op_rem_q   <= (req_i.req_type == dmrq_pkg::REQ_REMOVE);
            job_q      <= req_i.job_id;
            add_ok_q   <= add_ok;
            add_slot_q <= free_idx;
            found_q    <= 1'b0;
            best_vld_q <= add_ok;
            best_dl_q  <= req_i.rel_deadline;
            best_id_q  <= req_i.job_id;
            rd_idx_q   <= '0;
            state_q    <= StScan;
          end
        end
        StScan: begin
          rd_idx_q <= rd_idx_q + 1'b1;
          if (rd_idx_q == IdxLast) begin
            state_q <= StLast;
          end
        end
        StLast: begin
          state_q <= StFinish;
        end
        StFinish: begin
          if (finish) begin
            valid_q        <= valid_nxt;
            count_q        <= count_nxt;
            rsp_vld_q      <= 1'b1;
            rsp_head_vld_q <= best_vld_q;
            rsp_head_id_q  <= best_vld_q ? best_id_q : '0;
            rsp_count_q    <= dmrq_pkg::CountW'(count_nxt);
            rsp_err_q      <= op_rem_q ? !found_q : !add_ok_q;
            state_q        <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign rsp_o.valid       = rsp_vld_q;
  assign rsp_o.head_valid  = rsp_head_vld_q;
  assign rsp_o.head_job_id = rsp_head_id_q;
  assign rsp_o.job_count   = rsp_count_q;
  assign rsp_o.error       = rsp_err_q;

endmodule

@@ rtl/core/dmrq_chk.sv @@
// Port-level checker for the ready queue, bound to the top level.
// Depends on dmrq_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "deadline_monotonic_ready_queue_core_defines.svh"

module dmrq_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        req_valid_i,
  input logic                        req_ready_i,
  input logic                        rsp_valid_i,
  input logic                        rsp_ready_i,
  input logic                        head_valid_i,
  input logic [dmrq_pkg::JobW-1:0]   head_job_id_i,
  input logic [dmrq_pkg::CountW-1:0] job_count_i,
  input logic                        error_i
);

  // a stalled result keeps its word
  `DMRQ_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable({head_valid_i, head_job_id_i, job_count_i, error_i}), "rsp word changed while stalled")

  // an empty queue reports id zero
  `DMRQ_ASSERT_IMPLY(a_empty_id, rsp_valid_i && !head_valid_i, head_job_id_i == '0, "empty queue with nonzero head id")

  // head exists exactly when jobs are held
  `DMRQ_ASSERT_IMPLY(a_head_count, rsp_valid_i, head_valid_i == (job_count_i != '0), "head_valid disagrees with job_count")

  // the scan keeps the input closed after a word is taken
  `DMRQ_ASSERT(a_busy_after_accept, req_valid_i && req_ready_i |=> !req_ready_i, "req taken during scan")

endmodule

bind deadline_monotonic_ready_queue_core dmrq_chk u_dmrq_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .head_valid_i  (rsp_o.head_valid),
  .head_job_id_i (rsp_o.head_job_id),
  .job_count_i   (rsp_o.job_count),
  .error_i       (rsp_o.error)
);
